>>> design/rlie_pkg.sv
// shared types, opcode constants and helpers for the relative-long executor
package rlie_pkg;

	localparam int REG_COUNT = 16;
	localparam int REG_AW    = $clog2(REG_COUNT);

	// major opcodes
	localparam logic [7:0] MAJ_C0 = 8'hc0;
	localparam logic [7:0] MAJ_C4 = 8'hc4;
	localparam logic [7:0] MAJ_C6 = 8'hc6;

	// minor opcodes under c0
	localparam logic [3:0] FN_LARL   = 4'h0;
	// minor opcodes under c4
	localparam logic [3:0] FN_LLHRL  = 4'h2;
	localparam logic [3:0] FN_LGHRL  = 4'h4;
	localparam logic [3:0] FN_LHRL   = 4'h5;
	localparam logic [3:0] FN_LLGHRL = 4'h6;
	localparam logic [3:0] FN_STHRL  = 4'h7;
	localparam logic [3:0] FN_LGRL   = 4'h8;
	localparam logic [3:0] FN_STGRL  = 4'hb;
	localparam logic [3:0] FN_LGFRL  = 4'hc;
	localparam logic [3:0] FN_LRL    = 4'hd;
	localparam logic [3:0] FN_LLGFRL = 4'he;
	localparam logic [3:0] FN_STRL   = 4'hf;
	// minor opcodes under c6
	localparam logic [3:0] FN_PFDRL  = 4'h2;
	localparam logic [3:0] FN_CGHRL  = 4'h4;
	localparam logic [3:0] FN_CHRL   = 4'h5;
	localparam logic [3:0] FN_CLGHRL = 4'h6;
	localparam logic [3:0] FN_CLHRL  = 4'h7;
	localparam logic [3:0] FN_CGRL   = 4'h8;
	localparam logic [3:0] FN_CLGRL  = 4'ha;
	localparam logic [3:0] FN_CGFRL  = 4'hc;
	localparam logic [3:0] FN_CRL    = 4'hd;
	localparam logic [3:0] FN_CLGFRL = 4'he;
	localparam logic [3:0] FN_CLRL   = 4'hf;

	// operation classes
	localparam logic [2:0] OP_NONE     = 3'd0;
	localparam logic [2:0] OP_LARL     = 3'd1;
	localparam logic [2:0] OP_LOAD     = 3'd2;
	localparam logic [2:0] OP_STORE    = 3'd3;
	localparam logic [2:0] OP_PREFETCH = 3'd4;
	localparam logic [2:0] OP_CMP      = 3'd5;

	// operand sizes, same coding as the store size field
	localparam logic [1:0] SZ_HALF  = 2'd0;
	localparam logic [1:0] SZ_WORD  = 2'd1;
	localparam logic [1:0] SZ_DWORD = 2'd2;

	// exception kinds
	localparam logic [1:0] EXC_NONE = 2'd0;
	localparam logic [1:0] EXC_OPER = 2'd1;
	localparam logic [1:0] EXC_SPEC = 2'd2;
	localparam logic [1:0] EXC_ADDR = 2'd3;

	// program interruption codes
	localparam logic [15:0] PIC_OPER = 16'h0001;
	localparam logic [15:0] PIC_SPEC = 16'h0006;
	localparam logic [15:0] PIC_ADDR = 16'h0005;

	typedef struct packed {
		logic [2:0] kind;
		logic [1:0] size;
		logic       sgn;
		logic       low;
	} decode_t;

	function automatic decode_t decode(input logic [7:0] op, input logic [3:0] fn);
		decode_t d;
		d = '{kind: OP_NONE, size: SZ_DWORD, sgn: 1'b0, low: 1'b0};
		if (op == MAJ_C0) begin
			if (fn == FN_LARL) d.kind = OP_LARL;
		end else if (op == MAJ_C4) begin
			case (fn)
				FN_LLHRL:  d = '{OP_LOAD, SZ_HALF, 1'b0, 1'b1};
				FN_LGHRL:  d = '{OP_LOAD, SZ_HALF, 1'b1, 1'b0};
				FN_LHRL:   d = '{OP_LOAD, SZ_HALF, 1'b1, 1'b1};
				FN_LLGHRL: d = '{OP_LOAD, SZ_HALF, 1'b0, 1'b0};
				FN_LGRL:   d = '{OP_LOAD, SZ_DWORD, 1'b0, 1'b0};
				FN_LGFRL:  d = '{OP_LOAD, SZ_WORD, 1'b1, 1'b0};
				FN_LRL:    d = '{OP_LOAD, SZ_WORD, 1'b0, 1'b1};
				FN_LLGFRL: d = '{OP_LOAD, SZ_WORD, 1'b0, 1'b0};
				FN_STHRL:  d = '{OP_STORE, SZ_HALF, 1'b0, 1'b0};
				FN_STGRL:  d = '{OP_STORE, SZ_DWORD, 1'b0, 1'b0};
				FN_STRL:   d = '{OP_STORE, SZ_WORD, 1'b0, 1'b0};
				default: ;
			endcase
		end else if (op == MAJ_C6) begin
			case (fn)
				FN_PFDRL:  d.kind = OP_PREFETCH;
				FN_CGHRL:  d = '{OP_CMP, SZ_HALF, 1'b1, 1'b0};
				FN_CHRL:   d = '{OP_CMP, SZ_HALF, 1'b1, 1'b1};
				FN_CLGHRL: d = '{OP_CMP, SZ_HALF, 1'b0, 1'b0};
				FN_CLHRL:  d = '{OP_CMP, SZ_HALF, 1'b0, 1'b1};
				FN_CGRL:   d = '{OP_CMP, SZ_DWORD, 1'b1, 1'b0};
				FN_CLGRL:  d = '{OP_CMP, SZ_DWORD, 1'b0, 1'b0};
				FN_CGFRL:  d = '{OP_CMP, SZ_WORD, 1'b1, 1'b0};
				FN_CRL:    d = '{OP_CMP, SZ_WORD, 1'b1, 1'b1};
				FN_CLGFRL: d = '{OP_CMP, SZ_WORD, 1'b0, 1'b0};
				FN_CLRL:   d = '{OP_CMP, SZ_WORD, 1'b0, 1'b1};
				default: ;
			endcase
		end
		return d;
	endfunction

	// instruction length in bytes from the two top opcode bits
	function automatic logic [2:0] insn_len(input logic [7:0] op);
		case (op[7:6])
			2'b00:   return 3'd2;
			2'b11:   return 3'd6;
			default: return 3'd4;
		endcase
	endfunction

	function automatic logic [63:0] extend(input logic [63:0] v, input logic [1:0] sz,
			input logic sgn);
		case (sz)
			SZ_HALF: return {{48{sgn & v[15]}}, v[15:0]};
			SZ_WORD: return {{32{sgn & v[31]}}, v[31:0]};
			default: return v;
		endcase
	endfunction

endpackage

>>> design/rlie_ram.sv
// generic single-write, single-read ram with registered read data
module rlie_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end

endmodule

>>> design/relative_long_insn_executor_unit.sv
// relative-long load/store/compare executor, register file kept in a ram
//
//  port group   dir  width  beat contents
//  s_axis_*     in   184    opcode, func, reg, displacement, insn addr, mem data, fault
//  m_axis_*     out  280+2  next addr, operand addr, store, reg value, cc, code; kind
//  cfg_*        in   1      facility-installed bit
//
// one instruction per cycle unless output stalls; a beat passes s1 then the output reg
// stage s1 holds the decoded beat while the register file ram read completes
// the writeback of s1 is forwarded to a read of the same register issued in that cycle
// reset clears valid bits of all 16 registers (an unwritten register reads as zero), cc
// and the facility bit returns to one; no clearing pass
// output stall holds s1, which in turn holds back the input
module relative_long_insn_executor_unit import rlie_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// opcode_major, func, reg_index, displacement, instr_addr, mem_data, mem_fault
	input  logic [183:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// next_addr, operand_addr, store_enable, store_size, store_value, reg_value,
	// cond_code, interrupt_code
	output logic [279:0] m_axis_tdata,
	// exception_kind
	output logic [1:0]   m_axis_tuser,
	input  logic         cfg_we,
	input  logic         cfg_wdata
);

	// input beat fields
	logic [7:0]        in_op;
	logic [3:0]        in_fn;
	logic [REG_AW-1:0] in_reg;
	logic [31:0]       in_disp;
	logic [63:0]       in_ia;
	logic [63:0]       in_md;
	logic              in_mf;
	logic              in_acc;

	assign in_op   = s_axis_tdata[7:0];
	assign in_fn   = s_axis_tdata[11:8];
	assign in_reg  = s_axis_tdata[15:12];
	assign in_disp = s_axis_tdata[47:16];
	assign in_ia   = s_axis_tdata[111:48];
	assign in_md   = s_axis_tdata[175:112];
	assign in_mf   = s_axis_tdata[176];

	// control state
	logic                 fac_q;
	logic [1:0]           cc_q;
	logic [REG_COUNT-1:0] reg_vld_q;
	logic                 vld_s1;
	logic                 out_vld_q;

	// stage 1 payload
	decode_t           dec_s1;
	logic [REG_AW-1:0] reg_s1;
	logic [63:0]       oa_s1;
	logic [63:0]       na_s1;
	logic [2:0]        ilen_s1;
	logic [63:0]       md_s1;
	logic              mf_s1;
	logic              rvld_s1;
	logic              byp_s1;
	logic [63:0]       byp_data_s1;

	// output register
	logic [63:0] out_na_q;
	logic [63:0] out_oa_q;
	logic        out_sen_q;
	logic [1:0]  out_ssz_q;
	logic [63:0] out_sv_q;
	logic [63:0] out_rv_q;
	logic [1:0]  out_cc_q;
	logic [1:0]  out_exc_q;
	logic [18:0] out_icode_q;

	logic        s1_fire;
	logic [63:0] ram_rdata;
	logic [63:0] rv_old;
	logic [63:0] rv_new;
	logic [1:0]  cc_new;
	logic [1:0]  exc_c;
	logic        sen_c;
	logic [1:0]  ssz_c;
	logic [63:0] sv_c;
	logic [18:0] icode_c;
	logic        misal;
	logic [63:0] mem_ext;
	logic [63:0] cmp_m;
	logic [63:0] cmp_g;

	assign s1_fire       = vld_s1 && (!out_vld_q || m_axis_tready);
	assign s_axis_tready = !vld_s1 || s1_fire;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	rlie_ram #(.WIDTH(64), .DEPTH(REG_COUNT)) u_regfile (
		.clk   (clk),
		.we    (s1_fire),
		.waddr (reg_s1),
		.wdata (rv_new),
		.re    (in_acc),
		.raddr (in_reg),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fac_q     <= 1'b1;
			cc_q      <= 2'd0;
			reg_vld_q <= '0;
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_we) fac_q <= cfg_wdata;
			if (s1_fire) begin
				cc_q              <= cc_new;
				reg_vld_q[reg_s1] <= 1'b1;
			end
			if (s_axis_tready) vld_s1 <= s_axis_tvalid;
			if (s1_fire) out_vld_q <= 1'b1;
			else if (m_axis_tready) out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			dec_s1      <= decode(in_op, in_fn);
			reg_s1      <= in_reg;
			oa_s1       <= in_ia + {{31{in_disp[31]}}, in_disp, 1'b0};
			na_s1       <= in_ia + {61'd0, insn_len(in_op)};
			ilen_s1     <= insn_len(in_op);
			md_s1       <= in_md;
			mf_s1       <= in_mf;
			rvld_s1     <= reg_vld_q[in_reg];
			// writeback in this very cycle is not yet visible to the ram read
			byp_s1      <= s1_fire && (reg_s1 == in_reg);
			byp_data_s1 <= rv_new;
		end
	end

	always_comb begin
		if (byp_s1) rv_old = byp_data_s1;
		else if (rvld_s1) rv_old = ram_rdata;
		else rv_old = 64'd0;
	end

	always_comb begin
		case (dec_s1.size)
			SZ_HALF: misal = oa_s1[0];
			SZ_WORD: misal = |oa_s1[1:0];
			default: misal = |oa_s1[2:0];
		endcase
	end

	assign mem_ext = extend(md_s1, dec_s1.size, dec_s1.sgn);
	// sign flip turns the signed compare into an unsigned one
	assign cmp_m   = mem_ext ^ {dec_s1.sgn, 63'd0};
	assign cmp_g   = (dec_s1.low ? extend(rv_old, SZ_WORD, dec_s1.sgn) : rv_old)
		^ {dec_s1.sgn, 63'd0};

	always_comb begin
		exc_c  = EXC_NONE;
		rv_new = rv_old;
		cc_new = cc_q;
		sen_c  = 1'b0;
		ssz_c  = SZ_HALF;
		sv_c   = 64'd0;
		case (dec_s1.kind)
			OP_LARL: rv_new = oa_s1;
			OP_PREFETCH: if (!fac_q) exc_c = EXC_OPER;
			OP_LOAD, OP_STORE, OP_CMP: begin
				if (!fac_q) exc_c = EXC_OPER;
				else if (misal) exc_c = EXC_SPEC;
				else if (mf_s1) exc_c = EXC_ADDR;
				else if (dec_s1.kind == OP_LOAD) begin
					rv_new = dec_s1.low ? {rv_old[63:32], mem_ext[31:0]} : mem_ext;
				end else if (dec_s1.kind == OP_STORE) begin
					sen_c = 1'b1;
					ssz_c = dec_s1.size;
					sv_c  = extend(rv_old, dec_s1.size, 1'b0);
				end else begin
					if (cmp_m > cmp_g) cc_new = 2'd1;
					else if (cmp_m < cmp_g) cc_new = 2'd2;
					else cc_new = 2'd0;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		case (exc_c)
			EXC_OPER: icode_c = {ilen_s1, PIC_OPER};
			EXC_SPEC: icode_c = {ilen_s1, PIC_SPEC};
			EXC_ADDR: icode_c = {ilen_s1, PIC_ADDR};
			default:  icode_c = 19'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			out_na_q    <= na_s1;
			out_oa_q    <= oa_s1;
			out_sen_q   <= sen_c;
			out_ssz_q   <= ssz_c;
			out_sv_q    <= sv_c;
			out_rv_q    <= rv_new;
			out_cc_q    <= cc_new;
			out_exc_q   <= exc_c;
			out_icode_q <= icode_c;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {out_icode_q, out_cc_q, out_rv_q, out_sv_q, out_ssz_q, out_sen_q,
		out_oa_q, out_na_q};
	assign m_axis_tuser  = out_exc_q;

	a_exc_no_store: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && (out_exc_q != EXC_NONE) |-> !out_sen_q)
		else $error("store issued alongside an exception");

	a_icode_iff_exc: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> ((out_exc_q == EXC_NONE) == (out_icode_q == 19'd0)))
		else $error("interruption code disagrees with exception kind");

	a_exc_keeps_cc: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && (exc_c != EXC_NONE) |=> cc_q == $past(cc_q))
		else $error("condition code changed by an excepting instruction");

	a_fwd_capture: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && s1_fire && (reg_s1 == in_reg) |=> byp_s1 && (byp_data_s1 == $past(rv_new)))
		else $error("writeback to the register being read was not forwarded");

	a_store_size: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_sen_q |-> (out_ssz_q == SZ_HALF || out_ssz_q == SZ_WORD
			|| out_ssz_q == SZ_DWORD))
		else $error("store with an undefined size");

endmodule

>>> verif/tb_relative_long_insn_executor_unit.sv
// testbench for the relative-long executor: random and directed insns checked against a predictor
`timescale 1ns / 1ps

module tb_relative_long_insn_executor_unit import rlie_pkg::*;;

	// condition code values after a compare
	localparam logic [1:0] CC_EQUAL    = 2'd0;
	localparam logic [1:0] CC_MEM_HIGH = 2'd1;
	localparam logic [1:0] CC_MEM_LOW  = 2'd2;

	localparam int HOLD_CYCLES = 80;

	// one instruction beat, opcode field in the low bits
	typedef struct packed {
		logic        mf;
		logic [63:0] md;
		logic [63:0] ia;
		logic [31:0] disp;
		logic [3:0]  rn;
		logic [3:0]  fn;
		logic [7:0]  op;
	} insn_t;

	// one retired instruction as {tuser, tdata}
	typedef struct packed {
		logic [1:0]  exc;
		logic [18:0] pic;
		logic [1:0]  cc;
		logic [63:0] reg_val;
		logic [63:0] st_val;
		logic [1:0]  st_size;
		logic        st_en;
		logic [63:0] opnd_addr;
		logic [63:0] next_ia;
	} retire_t;

	typedef struct packed {
		logic [2:0] cls;
		logic [1:0] sz;
		logic       sgn;
		logic       low;
	} opsel_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [183:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [279:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         cfg_we = 1'b0;
	logic         cfg_wdata = 1'b0;

	// predictor state
	logic [63:0] gpr [REG_COUNT];
	logic [1:0]  cc_state;
	logic        facility_on;

	insn_t       pending_insns[$];
	retire_t     results_due[$];
	insn_t       insn_cur;
	int          insns_queued = 0;
	int          insns_issued = 0;
	int          insns_retired = 0;
	int          mismatch_count = 0;
	int          cls_seen [8];
	int          exc_seen [4];
	int          cfg_writes = 0;

	// handshake bookkeeping between the clock edges
	logic        in_beat_done = 1'b0;
	logic        out_beat_done = 1'b0;
	int unsigned src_gap = 0;
	int unsigned sink_wait = 0;
	int unsigned src_max = 3;
	int unsigned sink_max = 3;
	logic        hold_req = 1'b0;
	int          hold_left = 0;

	logic [3:0]  load_fns [8] = '{FN_LLHRL, FN_LGHRL, FN_LHRL, FN_LLGHRL,
		FN_LGRL, FN_LGFRL, FN_LRL, FN_LLGFRL};
	logic [3:0]  cmp_fns [10] = '{FN_CGHRL, FN_CHRL, FN_CLGHRL, FN_CLHRL, FN_CGRL,
		FN_CLGRL, FN_CGFRL, FN_CRL, FN_CLGFRL, FN_CLRL};
	logic [63:0] data_pool [10] = '{64'h0, '1, 64'h8000_0000_0000_0000,
		64'h7fff_ffff_ffff_ffff, 64'h0000_0000_8000_0000, 64'h0000_0000_7fff_ffff,
		64'h0000_0000_0000_8000, 64'h0000_0000_0000_7fff, 64'hffff_ffff_8000_0000,
		64'hffff_ffff_ffff_8000};

	relative_long_insn_executor_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tuser  (m_tuser),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	always #4 clk = ~clk;

	function automatic opsel_t classify(input logic [7:0] op, input logic [3:0] fn);
		opsel_t d;
		d = '{cls: OP_NONE, sz: SZ_DWORD, sgn: 1'b0, low: 1'b0};
		case (op)
			MAJ_C0: begin
				if (fn == FN_LARL) d.cls = OP_LARL;
			end
			MAJ_C4: begin
				case (fn)
					FN_LLHRL:  d = '{OP_LOAD, SZ_HALF, 1'b0, 1'b1};
					FN_LGHRL:  d = '{OP_LOAD, SZ_HALF, 1'b1, 1'b0};
					FN_LHRL:   d = '{OP_LOAD, SZ_HALF, 1'b1, 1'b1};
					FN_LLGHRL: d = '{OP_LOAD, SZ_HALF, 1'b0, 1'b0};
					FN_LGRL:   d = '{OP_LOAD, SZ_DWORD, 1'b0, 1'b0};
					FN_LGFRL:  d = '{OP_LOAD, SZ_WORD, 1'b1, 1'b0};
					FN_LRL:    d = '{OP_LOAD, SZ_WORD, 1'b0, 1'b1};
					FN_LLGFRL: d = '{OP_LOAD, SZ_WORD, 1'b0, 1'b0};
					FN_STHRL:  d = '{OP_STORE, SZ_HALF, 1'b0, 1'b0};
					FN_STRL:   d = '{OP_STORE, SZ_WORD, 1'b0, 1'b0};
					FN_STGRL:  d = '{OP_STORE, SZ_DWORD, 1'b0, 1'b0};
					default: ;
				endcase
			end
			MAJ_C6: begin
				case (fn)
					FN_PFDRL:  d.cls = OP_PREFETCH;
					FN_CGHRL:  d = '{OP_CMP, SZ_HALF, 1'b1, 1'b0};
					FN_CHRL:   d = '{OP_CMP, SZ_HALF, 1'b1, 1'b1};
					FN_CLGHRL: d = '{OP_CMP, SZ_HALF, 1'b0, 1'b0};
					FN_CLHRL:  d = '{OP_CMP, SZ_HALF, 1'b0, 1'b1};
					FN_CGRL:   d = '{OP_CMP, SZ_DWORD, 1'b1, 1'b0};
					FN_CLGRL:  d = '{OP_CMP, SZ_DWORD, 1'b0, 1'b0};
					FN_CGFRL:  d = '{OP_CMP, SZ_WORD, 1'b1, 1'b0};
					FN_CRL:    d = '{OP_CMP, SZ_WORD, 1'b1, 1'b1};
					FN_CLGFRL: d = '{OP_CMP, SZ_WORD, 1'b0, 1'b0};
					FN_CLRL:   d = '{OP_CMP, SZ_WORD, 1'b0, 1'b1};
					default: ;
				endcase
			end
			default: ;
		endcase
		return d;
	endfunction

	function automatic logic [63:0] widen(input logic [63:0] v, input logic [1:0] sz,
			input logic sgn);
		logic [63:0] w;
		w = v;
		if (sz == SZ_HALF) begin
			w[63:16] = (sgn && v[15]) ? '1 : '0;
		end else if (sz == SZ_WORD) begin
			w[63:32] = (sgn && v[31]) ? '1 : '0;
		end
		return w;
	endfunction

	// executes one instruction on the shadow registers and returns what should retire
	function automatic retire_t execute_insn(input insn_t i);
		opsel_t      d;
		retire_t     r;
		logic [63:0] oa, rv, m, g, align_mask, ilen;
		logic [8:0]  lsum;
		d = classify(i.op, i.fn);
		oa = i.ia + {{31{i.disp[31]}}, i.disp, 1'b0};
		// length 2, 4 or 6 from the opcode range
		lsum = (9'(i.op) + 9'd64) >> 7;
		ilen = 64'({lsum[1:0] + 2'd1, 1'b0});
		rv = gpr[i.rn];
		r = '0;
		r.next_ia = i.ia + ilen;
		r.opnd_addr = oa;
		align_mask = (d.sz == SZ_HALF) ? 64'd1 : (d.sz == SZ_WORD) ? 64'd3 : 64'd7;
		case (d.cls)
			OP_NONE: ;
			OP_LARL: rv = oa;
			OP_PREFETCH: begin
				if (!facility_on) r.exc = EXC_OPER;
			end
			default: begin
				if (!facility_on) r.exc = EXC_OPER;
				else if ((oa & align_mask) != '0) r.exc = EXC_SPEC;
				else if (i.mf) r.exc = EXC_ADDR;
				else if (d.cls == OP_LOAD) begin
					m = widen(i.md, d.sz, d.sgn);
					rv = d.low ? {rv[63:32], m[31:0]} : m;
				end else if (d.cls == OP_STORE) begin
					r.st_en = 1'b1;
					r.st_size = d.sz;
					r.st_val = widen(rv, d.sz, 1'b0);
				end else begin
					m = widen(i.md, d.sz, d.sgn);
					g = d.low ? widen(rv, SZ_WORD, d.sgn) : rv;
					// bias the sign bit so an unsigned compare orders signed values
					if (d.sgn) begin
						m[63] = ~m[63];
						g[63] = ~g[63];
					end
					cc_state = (m > g) ? CC_MEM_HIGH : (m < g) ? CC_MEM_LOW : CC_EQUAL;
				end
			end
		endcase
		gpr[i.rn] = rv;
		r.reg_val = rv;
		r.cc = cc_state;
		case (r.exc)
			EXC_OPER: r.pic = {ilen[2:0], PIC_OPER};
			EXC_SPEC: r.pic = {ilen[2:0], PIC_SPEC};
			EXC_ADDR: r.pic = {ilen[2:0], PIC_ADDR};
			default:  r.pic = '0;
		endcase
		cls_seen[d.cls]++;
		exc_seen[r.exc]++;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] seen);
		if (want !== seen) begin
			$error("%s: expected %h, got %h", name, want, seen);
			mismatch_count++;
		end
	endfunction

	function automatic insn_t mk(input logic [7:0] op, input logic [3:0] fn,
			input logic [3:0] rn, input logic [31:0] disp, input logic [63:0] ia,
			input logic [63:0] md, input logic mf);
		return '{mf: mf, md: md, ia: ia, disp: disp, rn: rn, fn: fn, op: op};
	endfunction

	function automatic logic [63:0] pick_data();
		if ($urandom_range(0, 4) < 2) return {$urandom, $urandom};
		return data_pool[$urandom_range(0, 9)];
	endfunction

	function automatic insn_t rand_insn();
		insn_t       i;
		int unsigned sel;
		sel = $urandom_range(0, 99);
		i.op = (sel < 15) ? MAJ_C0 : (sel < 50) ? MAJ_C4 : (sel < 85) ? MAJ_C6 :
			8'($urandom_range(0, 255));
		i.fn = 4'($urandom_range(0, 15));
		if (i.op == MAJ_C0 && $urandom_range(0, 4) != 0) i.fn = FN_LARL;
		i.rn = 4'($urandom_range(0, 15));
		case ($urandom_range(0, 3))
			0: i.disp = 32'($urandom_range(0, 255)) - 32'd128;
			1: i.disp = ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
			default: i.disp = $urandom;
		endcase
		i.ia = {$urandom, $urandom};
		// mostly doubleword aligned operand addresses so the access gets through
		if ($urandom_range(0, 3) != 0) begin
			i.ia[2:0] = '0;
			i.disp[1:0] = '0;
		end
		i.md = pick_data();
		i.mf = ($urandom_range(0, 9) == 0);
		return i;
	endfunction

	task automatic enqueue(input insn_t i);
		pending_insns.push_back(i);
		insns_queued++;
	endtask

	task automatic fill_random(input int n);
		insn_t a, b;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 4) == 0) begin
				// load then compare the same register against the same data
				a = rand_insn();
				a.op = MAJ_C4;
				a.fn = load_fns[$urandom_range(0, 7)];
				a.ia[2:0] = '0;
				a.disp[1:0] = '0;
				a.mf = 1'b0;
				b = rand_insn();
				b.op = MAJ_C6;
				b.fn = cmp_fns[$urandom_range(0, 9)];
				b.rn = a.rn;
				b.md = a.md;
				b.ia[2:0] = '0;
				b.disp[1:0] = '0;
				b.mf = 1'b0;
				enqueue(a);
				enqueue(b);
				k++;
			end else begin
				enqueue(rand_insn());
			end
		end
	endtask

	task automatic wait_idle();
		while (insns_issued != insns_queued || results_due.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_facility(input logic v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		facility_on = v;
		cfg_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// input side: an accepted beat is run on the predictor in the posedge block
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			results_due.push_back(execute_insn(insn_cur));
			insns_issued++;
			in_beat_done = 1'b1;
		end
	end

	always @(negedge clk) begin : feed
		logic nv;
		nv = s_tvalid;
		if (in_beat_done) begin
			in_beat_done = 1'b0;
			nv = 1'b0;
			src_gap = $urandom_range(0, src_max);
		end
		if (!nv && arst_n) begin
			if (src_gap > 0) begin
				src_gap--;
			end else if (pending_insns.size() > 0) begin
				insn_cur = pending_insns.pop_front();
				s_tdata <= {7'b0, insn_cur};
				nv = 1'b1;
			end
		end
		s_tvalid <= nv;
	end

	always @(posedge clk) begin : watch
		retire_t want, seen;
		if (arst_n && m_tvalid && m_tready) begin
			out_beat_done = 1'b1;
			insns_retired++;
			seen = {m_tuser, m_tdata};
			if (results_due.size() == 0) begin
				$error("result beat with no instruction outstanding");
				mismatch_count++;
			end else begin
				want = results_due.pop_front();
				check_field("next_addr", want.next_ia, seen.next_ia);
				check_field("operand_addr", want.opnd_addr, seen.opnd_addr);
				check_field("store_enable", 64'(want.st_en), 64'(seen.st_en));
				check_field("store_size", 64'(want.st_size), 64'(seen.st_size));
				check_field("store_value", want.st_val, seen.st_val);
				check_field("reg_value", want.reg_val, seen.reg_val);
				check_field("cond_code", 64'(want.cc), 64'(seen.cc));
				check_field("exception_kind", 64'(want.exc), 64'(seen.exc));
				check_field("interrupt_code", 64'(want.pic), 64'(seen.pic));
			end
		end
	end

	always @(negedge clk) begin : drain
		logic nr;
		if (out_beat_done) begin
			out_beat_done = 1'b0;
			sink_wait = $urandom_range(0, sink_max);
		end
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			nr = 1'b0;
		end else if (sink_wait > 0) begin
			sink_wait--;
			nr = 1'b0;
		end else begin
			nr = 1'b1;
		end
		m_tready <= nr;
	end

	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		for (int k = 0; k < REG_COUNT; k++) gpr[k] = '0;
		cc_state = CC_EQUAL;
		facility_on = 1'b1;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// address wrap both ways; larl ignores alignment and fault
		enqueue(mk(MAJ_C0, FN_LARL, 4'd1, 32'h7fff_ffff, 64'h0, 64'h0, 1'b0));
		enqueue(mk(MAJ_C0, FN_LARL, 4'd2, 32'h8000_0000, 64'h0, '1, 1'b1));
		enqueue(mk(MAJ_C0, FN_LARL, 4'd15, 32'h1, '1, 64'h0, 1'b0));
		// every load form; low-word loads keep the high word
		enqueue(mk(MAJ_C4, FN_LGRL, 4'd3, 32'h4, 64'h1000, 64'h0123_4567_89ab_cdef, 1'b0));
		enqueue(mk(MAJ_C4, FN_LRL, 4'd3, 32'h0, 64'h1000, 64'hffff_ffff_fedc_ba98, 1'b0));
		enqueue(mk(MAJ_C4, FN_LHRL, 4'd3, 32'h0, 64'h1000, 64'h5555_5555_5555_8001, 1'b0));
		enqueue(mk(MAJ_C4, FN_LLHRL, 4'd3, 32'h0, 64'h1000, 64'haaaa_aaaa_aaaa_ffff, 1'b0));
		enqueue(mk(MAJ_C4, FN_LGHRL, 4'd4, 32'h0, 64'h1000, 64'h0000_0000_0000_8000, 1'b0));
		enqueue(mk(MAJ_C4, FN_LLGHRL, 4'd5, 32'h0, 64'h1000, '1, 1'b0));
		enqueue(mk(MAJ_C4, FN_LGFRL, 4'd6, 32'h0, 64'h1000, 64'h0000_0000_8000_0000, 1'b0));
		enqueue(mk(MAJ_C4, FN_LLGFRL, 4'd7, 32'h0, 64'h1000, '1, 1'b0));
		enqueue(mk(MAJ_C4, FN_STHRL, 4'd3, 32'h0, 64'h2000, 64'h0, 1'b0));
		enqueue(mk(MAJ_C4, FN_STRL, 4'd3, 32'h0, 64'h2000, 64'h0, 1'b0));
		enqueue(mk(MAJ_C4, FN_STGRL, 4'd3, 32'h0, 64'h2000, 64'h0, 1'b0));
		// prefetch with a misaligned, faulting address raises nothing
		enqueue(mk(MAJ_C6, FN_PFDRL, 4'd0, 32'h0, 64'h1, 64'h0, 1'b1));
		// compares: memory greater, memory less, equal
		enqueue(mk(MAJ_C6, FN_CGRL, 4'd6, 32'h0, 64'h3000, 64'h0, 1'b0));
		enqueue(mk(MAJ_C6, FN_CLGRL, 4'd6, 32'h0, 64'h3000, 64'h0, 1'b0));
		enqueue(mk(MAJ_C6, FN_CHRL, 4'd4, 32'h0, 64'h3000, 64'h8000, 1'b0));
		enqueue(mk(MAJ_C6, FN_CLHRL, 4'd5, 32'h0, 64'h3000, 64'hffff, 1'b0));
		enqueue(mk(MAJ_C6, FN_CGHRL, 4'd3, 32'h0, 64'h3000, 64'h7fff, 1'b0));
		enqueue(mk(MAJ_C6, FN_CLGHRL, 4'd7, 32'h0, 64'h3000, 64'hffff, 1'b0));
		enqueue(mk(MAJ_C6, FN_CGFRL, 4'd6, 32'h0, 64'h3000, 64'h8000_0000, 1'b0));
		enqueue(mk(MAJ_C6, FN_CRL, 4'd6, 32'h0, 64'h3000, 64'h7fff_ffff, 1'b0));
		enqueue(mk(MAJ_C6, FN_CLGFRL, 4'd7, 32'h0, 64'h3000, 64'h1_0000_0000, 1'b0));
		enqueue(mk(MAJ_C6, FN_CLRL, 4'd6, 32'h0, 64'h3000, 64'h0, 1'b0));
		// misaligned beats fault, fault alone gives addressing
		enqueue(mk(MAJ_C4, FN_LRL, 4'd8, 32'h1, 64'h1000, 64'h0, 1'b0));
		enqueue(mk(MAJ_C4, FN_LGRL, 4'd8, 32'h0, 64'h1004, 64'h0, 1'b1));
		enqueue(mk(MAJ_C4, FN_STHRL, 4'd3, 32'h0, 64'h1000, 64'h0, 1'b1));
		// unhandled func and opcodes of the shorter lengths
		enqueue(mk(MAJ_C4, 4'h0, 4'd9, 32'h0, 64'h1000, 64'h0, 1'b0));
		enqueue(mk(8'h3f, FN_LGRL, 4'd9, 32'h0, 64'h1000, 64'h0, 1'b0));
		enqueue(mk(8'h80, FN_LGRL, 4'd9, 32'h0, '1, 64'h0, 1'b0));
		wait_idle();

		// facility removed: everything but larl and no-ops traps
		write_facility(1'b0);
		enqueue(mk(MAJ_C4, FN_LGRL, 4'd10, 32'h0, 64'h1000, '1, 1'b0));
		enqueue(mk(MAJ_C6, FN_PFDRL, 4'd10, 32'h0, 64'h1000, 64'h0, 1'b0));
		enqueue(mk(MAJ_C0, FN_LARL, 4'd10, 32'h3, 64'h1000, 64'h0, 1'b1));
		enqueue(mk(MAJ_C6, FN_CGRL, 4'd10, 32'h1, 64'h1000, 64'h0, 1'b1));
		enqueue(mk(MAJ_C4, FN_STGRL, 4'd10, 32'h0, 64'h1000, 64'h0, 1'b0));
		enqueue(mk(8'h00, 4'h0, 4'd10, 32'h0, 64'h1000, 64'h0, 1'b0));
		fill_random(150);
		wait_idle();

		// long receiver stall while the sender keeps pushing
		write_facility(1'b1);
		hold_req = 1'b1;
		fill_random(600);
		wait_idle();

		// back to back on both sides
		src_max = 0;
		sink_max = 0;
		fill_random(300);
		wait_idle();

		src_max = 3;
		sink_max = 3;
		write_facility(1'b0);
		fill_random(100);
		wait_idle();
		write_facility(1'b1);
		fill_random(450);
		wait_idle();

		repeat (6) @(posedge clk);
		$display("retired %0d insns: %0d larl, %0d loads, %0d stores, %0d compares, %0d prefetch",
			insns_retired, cls_seen[OP_LARL], cls_seen[OP_LOAD], cls_seen[OP_STORE],
			cls_seen[OP_CMP], cls_seen[OP_PREFETCH]);
		$display("traps: %0d operation, %0d specification, %0d addressing; %0d facility writes",
			exc_seen[EXC_OPER], exc_seen[EXC_SPEC], exc_seen[EXC_ADDR], cfg_writes);
		if (mismatch_count == 0 && results_due.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

>>> sim.f
design/rlie_pkg.sv
design/rlie_ram.sv
design/relative_long_insn_executor_unit.sv
verif/tb_relative_long_insn_executor_unit.sv
